// ===== design/mtf_pkg.sv =====
// Shared types and constants for the move-to-front coder.
package mtf_pkg;

   localparam int SYM_COUNT = 256;
   localparam int SYM_W     = 8;
   localparam int IDX_W     = (SYM_COUNT > 1) ? $clog2(SYM_COUNT) : 1;
   localparam int SIZE_W    = 9;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_RESTART = 2'd1,
      MODE_ENCODE  = 2'd2,
      MODE_DECODE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] value;
      logic [7:0] position;
   } req_type;

   typedef struct packed {
      logic [7:0] result_value;
      logic       error;
   } rsp_type;

   // Probe that walks the cell row during encode and decode.
   typedef struct packed {
      logic             valid;
      logic             decode;
      logic             found;
      logic [SYM_W-1:0] key;
      logic [IDX_W-1:0] pos;
      logic [SYM_W-1:0] sym;
   } token_type;

   // Broadcast controls from the sequencer to every cell.
   typedef struct packed {
      logic              load_en;
      logic [IDX_W-1:0]  load_pos;
      logic [SYM_W-1:0]  load_val;
      logic              restart;
      logic              shift_en;
      logic [IDX_W-1:0]  shift_pos;
      logic [SYM_W-1:0]  front_sym;
      logic [SIZE_W-1:0] size;
   } ctl_type;

endpackage

// ===== design/mtf_cell.sv =====
// One table cell: initial entry, working entry and one probe stage.
module mtf_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mtf_pkg::IDX_W-1:0]      cell_index,
   input  mtf_pkg::ctl_type               ctl,
   input  logic [mtf_pkg::SYM_W-1:0]      prev_work,
   input  mtf_pkg::token_type             tok_in,
   output mtf_pkg::token_type             tok_out,
   output logic [mtf_pkg::SYM_W-1:0]      work_out
);

   logic [mtf_pkg::SYM_W-1:0] work_ff, work_in;
   logic [mtf_pkg::SYM_W-1:0] init_ff, init_in;
   mtf_pkg::token_type        tok_ff, tok_in_next;
   logic                      active;
   logic                      hit;

   always_comb begin
      active = mtf_pkg::SIZE_W'(cell_index) < ctl.size;
      if (tok_in.decode) begin
         hit = (tok_in.key == mtf_pkg::SYM_W'(cell_index));
      end else begin
         hit = (tok_in.key == work_ff);
      end
      tok_in_next = tok_in;
      // first active match claims the probe
      if (tok_in.valid && !tok_in.found && active && hit) begin
         tok_in_next.found = 1'b1;
         tok_in_next.pos   = cell_index;
         tok_in_next.sym   = work_ff;
      end
   end

   always_comb begin
      priority if (ctl.restart) begin
         work_in = init_ff;
      end else if (ctl.shift_en && (cell_index <= ctl.shift_pos)) begin
         work_in = prev_work;
      end else begin
         work_in = work_ff;
      end
   end

   always_comb begin
      if (ctl.load_en && (ctl.load_pos == cell_index)) begin
         init_in = ctl.load_val;
      end else begin
         init_in = init_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= mtf_pkg::SYM_W'(cell_index);
         init_ff <= mtf_pkg::SYM_W'(cell_index);
         tok_ff  <= '0;
      end else begin
         work_ff <= work_in;
         init_ff <= init_in;
         tok_ff  <= tok_in_next;
      end
   end

   assign tok_out  = tok_ff;
   assign work_out = work_ff;

endmodule

// ===== design/mtf_ctrl.sv =====
// Sequencer: handshakes, size register, probe launch, table update and result buffering.
module mtf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mtf_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mtf_pkg::rsp_type     rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [8:0]           csr_data,
   input  mtf_pkg::token_type   last_tok,
   output mtf_pkg::token_type   launch_tok,
   output mtf_pkg::ctl_type     ctl
);

   mtf_pkg::state_type         state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mtf_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   mtf_pkg::rsp_type           skid_ff, skid_in;
   logic [mtf_pkg::SIZE_W-1:0] size_ff, size_in;

   logic             req_fire;
   logic             scan_mode;
   logic             ctrl_fire;
   logic             scan_end;
   logic             done;
   logic             pop;
   logic             out_free;
   logic             out_load;
   logic             out_skid;
   logic             skid_load;
   mtf_pkg::rsp_type word;

   assign req_fire  = req_valid && !req_stall;
   assign scan_mode = (req_data.mode == mtf_pkg::MODE_ENCODE) ||
                      (req_data.mode == mtf_pkg::MODE_DECODE);
   assign ctrl_fire = req_fire && !scan_mode;
   assign scan_end  = (state_ff == mtf_pkg::ST_SCAN) && last_tok.valid;
   assign done      = ctrl_fire || scan_end;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || pop;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mtf_pkg::ST_IDLE: begin
            if (req_fire && scan_mode) begin
               state_in = mtf_pkg::ST_SCAN;
            end else if (ctrl_fire && !out_free) begin
               state_in = mtf_pkg::ST_HOLD;
            end
         end
         mtf_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = out_free ? mtf_pkg::ST_IDLE : mtf_pkg::ST_HOLD;
            end
         end
         mtf_pkg::ST_HOLD: begin
            if (pop) begin
               state_in = mtf_pkg::ST_IDLE;
            end
         end
         default: state_in = mtf_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_stall = (state_ff != mtf_pkg::ST_IDLE);
      csr_ready = 1'b1;

      word = '0;
      if (scan_end) begin
         word.error = !last_tok.found;
         if (last_tok.found) begin
            word.result_value = last_tok.decode ? last_tok.sym : 8'(last_tok.pos);
         end
      end

      out_load  = 1'b0;
      out_skid  = 1'b0;
      skid_load = 1'b0;
      unique case (state_ff)
         mtf_pkg::ST_IDLE,
         mtf_pkg::ST_SCAN: begin
            out_load  = done && out_free;
            skid_load = done && !out_free;
         end
         mtf_pkg::ST_HOLD: begin
            out_skid = pop;
         end
         default: ;
      endcase

      rsp_valid_in = out_load || out_skid || (rsp_valid_ff && !pop);
      priority if (out_skid) begin
         rsp_data_in = skid_ff;
      end else if (out_load) begin
         rsp_data_in = word;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
      skid_in = skid_load ? word : skid_ff;

      size_in = (csr_valid && csr_ready) ? csr_data : size_ff;

      launch_tok        = '0;
      launch_tok.valid  = req_fire && scan_mode;
      launch_tok.decode = (req_data.mode == mtf_pkg::MODE_DECODE);
      launch_tok.key    = req_data.value;

      ctl.load_en   = ctrl_fire && (req_data.mode == mtf_pkg::MODE_LOAD) &&
                      (mtf_pkg::SIZE_W'(req_data.position) < mtf_pkg::SIZE_W'(mtf_pkg::SYM_COUNT));
      ctl.load_pos  = mtf_pkg::IDX_W'(req_data.position);
      ctl.load_val  = req_data.value;
      ctl.restart   = ctrl_fire && (req_data.mode == mtf_pkg::MODE_RESTART);
      ctl.shift_en  = scan_end && last_tok.found;
      ctl.shift_pos = last_tok.pos;
      ctl.front_sym = last_tok.sym;
      if (size_ff > mtf_pkg::SIZE_W'(mtf_pkg::SYM_COUNT)) begin
         ctl.size = mtf_pkg::SIZE_W'(mtf_pkg::SYM_COUNT);
      end else begin
         ctl.size = size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= mtf_pkg::SIZE_W'(256);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      skid_ff     <= skid_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/move_to_front_coder.sv =====
// Top level of the move-to-front coder: sequencer and the row of table cells.
//
//   channel   direction  handshake        word
//   req_      in         valid / stall    mtf_pkg::req_type (mode, value, position)
//   rsp_      out        valid / stall    mtf_pkg::rsp_type (result_value, error)
//   csr_      in         valid / ready    alphabet_size, 9 bits
//
// Load and restart are answered without a probe. Encode and decode send a probe
// along the cell row one cell per clock, and the table update happens as it
// leaves the last cell.
// Synchronous reset sets both tables to identity at once and the size to 256.
// A stalled result sits in the output register; one more result can wait in a
// skid register, after which req_stall holds until the output drains.
module move_to_front_coder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [8:0]       csr_data
);

   mtf_pkg::token_type        launch_tok;
   mtf_pkg::ctl_type          ctl;
   mtf_pkg::token_type        tok_vec  [mtf_pkg::SYM_COUNT];
   logic [mtf_pkg::SYM_W-1:0] work_vec [mtf_pkg::SYM_COUNT];
   logic [mtf_pkg::SYM_COUNT-1:0] tok_valid_vec;

   mtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .last_tok   (tok_vec[mtf_pkg::SYM_COUNT-1]),
      .launch_tok (launch_tok),
      .ctl        (ctl)
   );

   for (genvar k = 0; k < mtf_pkg::SYM_COUNT; k++) begin : g_cell
      mtf_pkg::token_type        tok_prev;
      logic [mtf_pkg::SYM_W-1:0] work_prev;

      if (k == 0) begin : g_head
         assign tok_prev  = launch_tok;
         assign work_prev = ctl.front_sym;
      end else begin : g_body
         assign tok_prev  = tok_vec[k-1];
         assign work_prev = work_vec[k-1];
      end

      mtf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (mtf_pkg::IDX_W'(k)),
         .ctl        (ctl),
         .prev_work  (work_prev),
         .tok_in     (tok_prev),
         .tok_out    (tok_vec[k]),
         .work_out   (work_vec[k])
      );

      assign tok_valid_vec[k] = tok_vec[k].valid;
   end

   a_one_probe: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid_vec) <= 1)
      else $error("more than one probe in the cell row");

   a_probe_busy: assert property (@(posedge clock) disable iff (reset)
      (tok_valid_vec != '0) |-> req_stall)
      else $error("input taken while a probe is in flight");

   a_probe_launch: assert property (@(posedge clock) disable iff (reset)
      tok_valid_vec[0] |-> $past(req_valid && !req_stall))
      else $error("probe entered the row without an accepted word");

endmodule

// ===== tb/move_to_front_coder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the move-to-front coder: random-gap driver, stalling monitor.
module move_to_front_coder_tb;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   mtf_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   mtf_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [8:0]       csr_data;

   move_to_front_coder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Shadow copy of the coder state
   logic [7:0] seed_table [mtf_pkg::SYM_COUNT];
   logic [7:0] live_table [mtf_pkg::SYM_COUNT];
   logic [8:0] alphabet_size;

   mtf_pkg::req_type pending_words[$];
   mtf_pkg::rsp_type expected_results[$];
   logic    req_fire;
   logic    calm;
   int      req_gap;
   int      rsp_gap;
   int      fail_count;
   int      words_sent;
   int      results_checked;
   int      sizes_used;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout: %0d results still expected", expected_results.size());
      $display("move_to_front_coder_tb: errors");
      $finish;
   end

   function automatic void bring_to_front(int idx);
      logic [7:0] sym;
      int         k;
      sym = live_table[idx];
      for (k = idx; k > 0; k--)
         live_table[k] = live_table[k - 1];
      live_table[0] = sym;
   endfunction

   function automatic mtf_pkg::rsp_type code_word(mtf_pkg::req_type w);
      mtf_pkg::rsp_type r;
      int      n;
      int      i;
      int      hit;
      r   = '0;
      hit = -1;
      n   = (int'(alphabet_size) > mtf_pkg::SYM_COUNT) ? mtf_pkg::SYM_COUNT :
            int'(alphabet_size);
      unique case (w.mode)
         mtf_pkg::MODE_LOAD: begin
            if (int'(w.position) < mtf_pkg::SYM_COUNT)
               seed_table[w.position] = w.value;
         end
         mtf_pkg::MODE_RESTART: begin
            for (i = 0; i < mtf_pkg::SYM_COUNT; i++)
               live_table[i] = seed_table[i];
         end
         mtf_pkg::MODE_ENCODE: begin
            // nearest copy to the front wins
            for (i = 0; i < n && hit < 0; i++)
               if (live_table[i] == w.value)
                  hit = i;
            if (hit >= 0) begin
               r.result_value = hit[7:0];
               bring_to_front(hit);
            end else begin
               r.error = 1'b1;
            end
         end
         default: begin
            if (int'(w.value) < n) begin
               r.result_value = live_table[w.value];
               bring_to_front(int'(w.value));
            end else begin
               r.error = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   function automatic void queue_word(mtf_pkg::mode_type m, logic [7:0] v, logic [7:0] p);
      mtf_pkg::req_type w;
      w.mode     = m;
      w.value    = v;
      w.position = p;
      pending_words.push_back(w);
      words_sent++;
   endfunction

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_alphabet_size(input logic [8:0] sz);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= sz;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      alphabet_size = sz;
      sizes_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Request driver: hold a stalled word, drop it once taken, insert idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold
      end else begin
         if (req_valid)
            void'(pending_words.pop_front());
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 9);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_words[0];
         end
      end
   end

   // Result back-pressure in bursts
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on each accepted word, check each accepted result against the oldest
   always @(posedge clock) begin
      mtf_pkg::rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_results.push_back(code_word(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: result expected none actual %h", $time, rsp_data);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_data.result_value !== want.result_value) begin
                  fail_count++;
                  $display("%0t: result_value expected %h actual %h",
                           $time, want.result_value, rsp_data.result_value);
               end
               if (rsp_data.error !== want.error) begin
                  fail_count++;
                  $display("%0t: error expected %b actual %b",
                           $time, want.error, rsp_data.error);
               end
            end
         end
      end
   end

   initial begin
      logic [8:0] size_plan [9];
      int         p;
      int         n;
      int         k;
      int         pick;
      int         count;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data  = '0;
      calm      = 1'b0;
      req_gap   = 0;
      rsp_gap   = 0;
      fail_count      = 0;
      words_sent      = 0;
      results_checked = 0;
      sizes_used      = 0;
      for (k = 0; k < mtf_pkg::SYM_COUNT; k++) begin
         seed_table[k] = k[7:0];
         live_table[k] = k[7:0];
      end
      alphabet_size = 9'd256;
      size_plan = '{9'd256, 9'd2, 9'd17, 9'd0, 9'd255, 9'd300, 9'd1, 9'd0, 9'd256};
      size_plan[3] = 9'($urandom_range(1, 256));
      size_plan[7] = 9'($urandom_range(1, 64));

      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset tables and size, table extremes, repeated symbols, absent symbol
      queue_word(mtf_pkg::MODE_ENCODE, 8'h00, 8'($urandom));
      queue_word(mtf_pkg::MODE_ENCODE, 8'hFF, 8'($urandom));
      queue_word(mtf_pkg::MODE_DECODE, 8'hFF, 8'($urandom));
      queue_word(mtf_pkg::MODE_DECODE, 8'h00, 8'($urandom));
      queue_word(mtf_pkg::MODE_ENCODE, 8'hFE, 8'($urandom));
      queue_word(mtf_pkg::MODE_LOAD, 8'hFF, 8'h00);
      queue_word(mtf_pkg::MODE_LOAD, 8'hFF, 8'h01);
      queue_word(mtf_pkg::MODE_LOAD, 8'h00, 8'hFF);
      queue_word(mtf_pkg::MODE_RESTART, 8'($urandom), 8'($urandom));
      queue_word(mtf_pkg::MODE_ENCODE, 8'hFF, 8'($urandom));
      queue_word(mtf_pkg::MODE_ENCODE, 8'h01, 8'($urandom));
      queue_word(mtf_pkg::MODE_ENCODE, 8'h00, 8'($urandom));
      queue_word(mtf_pkg::MODE_DECODE, 8'h01, 8'($urandom));
      wait_drained();

      // Empty alphabet: every lookup fails
      write_alphabet_size(9'd0);
      queue_word(mtf_pkg::MODE_ENCODE, 8'h00, 8'h00);
      queue_word(mtf_pkg::MODE_DECODE, 8'h00, 8'hFF);
      queue_word(mtf_pkg::MODE_LOAD, 8'h05, 8'h02);
      queue_word(mtf_pkg::MODE_RESTART, 8'h00, 8'h00);
      wait_drained();

      // Size above the table saturates
      write_alphabet_size(9'h1FF);
      queue_word(mtf_pkg::MODE_DECODE, 8'hFF, 8'h00);
      queue_word(mtf_pkg::MODE_ENCODE, 8'h05, 8'h00);
      wait_drained();

      // Single entry: only the front counts
      write_alphabet_size(9'd1);
      queue_word(mtf_pkg::MODE_DECODE, 8'h00, 8'h00);
      queue_word(mtf_pkg::MODE_DECODE, 8'h01, 8'h00);
      queue_word(mtf_pkg::MODE_ENCODE, 8'h05, 8'h00);
      queue_word(mtf_pkg::MODE_ENCODE, 8'hFF, 8'h00);
      wait_drained();

      // Random streams: a few loads, restart, then mostly in-alphabet codes
      for (p = 0; p < 9; p++) begin
         wait_drained();
         write_alphabet_size(size_plan[p]);
         n = (int'(size_plan[p]) > mtf_pkg::SYM_COUNT) ? mtf_pkg::SYM_COUNT :
             int'(size_plan[p]);
         calm = (p == 8);
         count = 0;
         while (count < 55) begin
            k = $urandom_range(0, 3);
            repeat (k) begin
               queue_word(mtf_pkg::MODE_LOAD, 8'($urandom_range(0, n - 1)),
                          8'($urandom_range(0, n - 1)));
               count++;
            end
            if ($urandom_range(0, 4) != 0) begin
               queue_word(mtf_pkg::MODE_RESTART, 8'($urandom), 8'($urandom));
               count++;
            end
            repeat ($urandom_range(4, 12)) begin
               pick = $urandom_range(0, 9);
               if (pick < 4)
                  queue_word(mtf_pkg::MODE_ENCODE, 8'($urandom_range(0, n - 1)),
                             8'($urandom));
               else if (pick < 8)
                  queue_word(mtf_pkg::MODE_DECODE, 8'($urandom_range(0, n - 1)),
                             8'($urandom));
               else if (pick == 8)
                  queue_word(mtf_pkg::MODE_ENCODE, 8'($urandom), 8'($urandom));
               else
                  queue_word(mtf_pkg::mode_type'($urandom_range(0, 3)), 8'($urandom),
                             8'($urandom));
               count++;
            end
         end
      end

      wait_drained();
      repeat (300) @(posedge clock);
      $display("sent %0d words over %0d alphabet size settings, checked %0d results",
               words_sent, sizes_used, results_checked);
      if (fail_count == 0)
         $display("move_to_front_coder_tb: clean");
      else
         $display("move_to_front_coder_tb: errors");
      $finish;
   end

endmodule
